// ===== hw/rtl/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants for the signed-count run-length encoder.
// ----------------------------------------------------------------------------
package rle_pkg;
    localparam int MAX_GROUP_DEF  = 127;
    localparam int WORD_BYTES_DEF = 8;
    localparam int STORE_DEPTH    = 128;
    localparam logic [23:0] LIMIT_RESET = 24'hFFFFFF;
endpackage

// ===== hw/rtl/rle_ram.sv =====
// ----------------------------------------------------------------------------
// rle_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/rle_signed_count_encoder_top.sv =====
// ----------------------------------------------------------------------------
// rle_signed_count_encoder_top
// Run-length encoder with signed group headers and little-endian word packing.
// ----------------------------------------------------------------------------
// Flow: a byte that only extends the open group leaves the encoder in S_IDLE, so the
// input stays free unless the output register still holds a word. A byte that closes
// a group passes through S_HDR and S_BODY, pushing each encoded byte through the shared
// byte packer, and a new group left open at a block end goes through them as well; a
// block end adds S_FLUSH, with S_LIT first when no group closed, and output stall holds it all.
// Reset: asynchronous active low; clears control state, limit_reg resets to all ones.
module rle_signed_count_encoder_top #(
    parameter int MAX_GROUP  = rle_pkg::MAX_GROUP_DEF,
    parameter int WORD_BYTES = rle_pkg::WORD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        block_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_word,
    output logic [3:0]  byte_count,
    output logic        final_word,
    output logic        overflow,
    output logic [23:0] total_bytes
);
    localparam int AW = $clog2(rle_pkg::STORE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_HDR, S_BODY, S_LIT, S_FLUSH, S_OUT
    } state_t;

    state_t       state_reg;
    logic [23:0]  limit_reg;
    logic [8:0]   gc_reg;        // signed group count
    logic [7:0]   prev_reg;
    logic [63:0]  pack_reg;
    logic [3:0]   fill_reg;
    logic [23:0]  sofar_reg;
    logic         disc_reg;
    // pending close: header byte, count of literals, after-close group value
    logic [7:0]   hdr_reg;
    logic         run_reg;       // closing group is a run
    logic [7:0]   runb_reg;
    logic [7:0]   lcnt_reg;
    logic [7:0]   lidx_reg;
    logic [8:0]   gnew_reg;
    logic         end_reg;
    logic         any_reg;       // a word was emitted for this item
    logic [7:0]   lit0_reg;      // first literal of the open group
    // output register
    logic         ov_reg;
    logic [63:0]  ow_reg;
    logic [3:0]   oc_reg;
    logic         of_reg;
    logic         oo_reg;
    logic [23:0]  ot_reg;

    logic         ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]   ram_wdata, ram_rdata;

    rle_ram #(.WIDTH(8), .DEPTH(rle_pkg::STORE_DEPTH)) u_store (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    wire accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_word = ow_reg;
    assign byte_count = oc_reg;
    assign final_word = of_reg;
    assign overflow = oo_reg;
    assign total_bytes = ot_reg;

    // evaluation of the incoming byte
    logic signed [8:0] gcs;
    logic        same, is_pos, full;
    logic [1:0]  add;
    logic [24:0] total;
    logic        do_close;
    logic [8:0]  gnew;
    logic        wr_two;
    always_comb
    begin
        gcs    = $signed(gc_reg);
        same   = (data_byte == prev_reg);
        is_pos = gcs > 0;
        full   = (gcs >= MAX_GROUP) || (gcs <= -MAX_GROUP);
        if (gcs == 0)
            add = 2'd2;
        else if (same)
            add = (gcs < 0) ? 2'd1 : (full ? 2'd2 : 2'd0);
        else if (gcs == 1)
            add = 2'd1;
        else if (is_pos || full)
            add = 2'd2;
        else
            add = 2'd1;
        total = {1'b0, sofar_reg} + {23'd0, add};
        do_close = 1'b0;
        gnew = 9'd1;
        wr_two = 1'b0;
        if (gcs == 0)
            gnew = 9'd1;
        else if (same)
        begin
            if (gcs < 0)
            begin
                do_close = 1'b1;
                gnew = 9'd2;
            end
            else if (full)
            begin
                do_close = 1'b1;
                gnew = 9'd1;
            end
            else
                gnew = gc_reg + 9'd1;
        end
        else if (gcs == 1)
        begin
            wr_two = 1'b1;
            gnew = -9'sd2;
        end
        else if (is_pos || full)
        begin
            do_close = 1'b1;
            gnew = 9'd1;
        end
        else
            gnew = gc_reg - 9'd1;
    end

    // closing group as seen at the close point (shrunk literal group included)
    logic signed [8:0] cgs;
    always_comb
    begin
        cgs = (same && gcs < 0) ? gcs + 9'sd1 : gcs;
    end

    // The packer moves on when the output register is free or being drained.
    logic        advance;
    logic        last_push;
    always_comb
    begin
        advance   = (state_reg == S_BODY) && (!ov_reg || !out_stall) && (lcnt_reg != 8'd1);
        last_push = (state_reg == S_BODY) && (lcnt_reg == 8'd1) && end_reg &&
                    (gnew_reg == 9'd0);
    end

    // the one shared unit: push a byte into the packer
    logic [7:0]  pbyte;
    logic [63:0] pack_ins;
    logic        word_full;
    always_comb
    begin
        pack_ins  = pack_reg | ({56'd0, pbyte} << {fill_reg[2:0], 3'b000});
        word_full = (fill_reg + 4'd1) >= 4'(WORD_BYTES);
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = data_byte;
        if (state_reg == S_IDLE && accept && !disc_reg && total <= {1'b0, limit_reg})
        begin
            if (wr_two)
            begin
                ram_we = 1'b1;
                ram_waddr = AW'(1);
            end
            else if (!do_close && gcs < -1)
            begin
                ram_we = 1'b1;
                ram_waddr = AW'(-gcs);
            end
        end
        // Read one entry ahead so the registered data matches the index in use.
        ram_raddr = advance ? lidx_reg[AW-1:0] + AW'(1) : lidx_reg[AW-1:0];
    end

    always_comb
    begin
        unique case (state_reg)
            S_HDR:   pbyte = hdr_reg;
            S_BODY:  pbyte = run_reg ? runb_reg :
                             ((lidx_reg == 8'd0) ? lit0_reg : ram_rdata);
            default: pbyte = hdr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= rle_pkg::LIMIT_RESET;
            gc_reg <= '0; prev_reg <= '0; pack_reg <= '0; fill_reg <= '0;
            sofar_reg <= '0; disc_reg <= 1'b0; ov_reg <= 1'b0;
            hdr_reg <= '0; run_reg <= 1'b0; runb_reg <= '0; lcnt_reg <= '0;
            lidx_reg <= '0; gnew_reg <= '0; end_reg <= 1'b0; any_reg <= 1'b0;
            lit0_reg <= '0;
            ow_reg <= '0; oc_reg <= '0; of_reg <= 1'b0; oo_reg <= 1'b0; ot_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        any_reg <= 1'b0;
                        end_reg <= block_end;
                        if (disc_reg)
                        begin
                            if (block_end)
                            begin
                                disc_reg <= 1'b0; gc_reg <= '0; sofar_reg <= '0;
                                pack_reg <= '0; fill_reg <= '0;
                            end
                        end
                        else if (total > {1'b0, limit_reg})
                        begin
                            gc_reg <= '0; sofar_reg <= '0; pack_reg <= '0; fill_reg <= '0;
                            disc_reg <= !block_end;
                            ov_reg <= 1'b1; ow_reg <= '0; oc_reg <= '0; of_reg <= 1'b1;
                            oo_reg <= 1'b1; ot_reg <= '0;
                        end
                        else
                        begin
                            sofar_reg <= total[23:0];
                            prev_reg <= data_byte;
                            if (wr_two)
                                lit0_reg <= prev_reg;
                            if (do_close)
                            begin
                                run_reg  <= cgs > 0;
                                runb_reg <= prev_reg;
                                hdr_reg  <= cgs[7:0];
                                lcnt_reg <= (cgs > 0) ? 8'd1 : 8'(-cgs);
                                lidx_reg <= '0;
                                gnew_reg <= gnew;
                                gc_reg   <= '0;
                                state_reg <= S_HDR;
                            end
                            else
                            begin
                                gc_reg <= gnew;
                                if (block_end)
                                begin
                                    run_reg  <= $signed(gnew) > 0;
                                    runb_reg <= data_byte;
                                    hdr_reg  <= gnew[7:0];
                                    lcnt_reg <= ($signed(gnew) > 0) ? 8'd1 : 8'(-gnew);
                                    lidx_reg <= '0;
                                    gnew_reg <= '0;
                                    state_reg <= S_LIT;
                                end
                            end
                        end
                    end
                end
                S_LIT:
                begin
                    // settling state so the last store write lands before the body is read
                    state_reg <= S_HDR;
                    end_reg <= 1'b1;
                end
                S_HDR, S_BODY:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        if (word_full)
                        begin
                            ov_reg <= 1'b1; ow_reg <= pack_ins; oc_reg <= 4'(WORD_BYTES);
                            of_reg <= last_push; oo_reg <= 1'b0;
                            ot_reg <= last_push ? sofar_reg : '0;
                            pack_reg <= '0; fill_reg <= '0; any_reg <= 1'b1;
                        end
                        else
                        begin
                            pack_reg <= pack_ins; fill_reg <= fill_reg + 4'd1;
                        end
                        if (state_reg == S_HDR)
                        begin
                            state_reg <= S_BODY;
                        end
                        else if (lcnt_reg == 8'd1)
                        begin
                            if (end_reg && gnew_reg != 9'd0)
                            begin
                                // block ended with a group still open after the close
                                run_reg  <= $signed(gnew_reg) > 0;
                                hdr_reg  <= gnew_reg[7:0];
                                runb_reg <= prev_reg;
                                lcnt_reg <= 8'd1;
                                gnew_reg <= '0;
                                gc_reg   <= '0;
                                state_reg <= S_HDR;
                            end
                            else
                            begin
                                gc_reg <= gnew_reg;
                                state_reg <= end_reg ? S_FLUSH : S_IDLE;
                            end
                        end
                        else
                        begin
                            lcnt_reg <= lcnt_reg - 8'd1;
                            lidx_reg <= lidx_reg + 8'd1;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (fill_reg == 4'd0 && any_reg)
                    begin
                        // The last full word already went out marked as final.
                        state_reg <= S_IDLE;
                        gc_reg <= '0; sofar_reg <= '0;
                    end
                    else if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1; ow_reg <= pack_reg; oc_reg <= fill_reg;
                        of_reg <= 1'b1; oo_reg <= 1'b0; ot_reg <= sofar_reg;
                        state_reg <= S_IDLE;
                        gc_reg <= '0; sofar_reg <= '0; pack_reg <= '0; fill_reg <= '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(byte_count)
            && $stable(final_word) && $stable(overflow) && $stable(total_bytes));
    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> final_word && byte_count == 4'd0 && total_bytes == 24'd0);
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count <= 4'(WORD_BYTES));
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall);
endmodule
